// ===== src/cellset_ownership_mapper_unit_assert.svh =====
// Assertion macros for the cellset ownership mapper.
// Used by cellset_ownership_mapper_unit; no other dependencies.
`ifndef CELLSET_OWNERSHIP_MAPPER_UNIT_ASSERT_SVH
`define CELLSET_OWNERSHIP_MAPPER_UNIT_ASSERT_SVH

// same-cycle implication
`define CSOM_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("csom: same-cycle check failed");

// next-cycle implication
`define CSOM_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("csom: next-cycle check failed");

`endif

// ===== src/csom_pkg.sv =====
// Shared widths, register indexes, command codes and divider word types
// for the cellset ownership mapper. No dependencies.
`default_nettype none

package csom_pkg;

   localparam int ID_W       = 18;
   localparam int NCNT_W     = 7;
   localparam int OVL_W      = 3;
   localparam int LIDX_W     = 12;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 7;

   localparam int DVD_W      = 18;
   localparam int DVS_W      = 14;
   localparam int DIV_CNT_W  = $clog2(DVD_W);

   localparam int BASE_W     = 21;
   localparam int MUL_A_W    = 23;
   localparam int MUL_B_W    = 14;
   localparam int PROD_W     = MUL_A_W + MUL_B_W + 1;
   localparam int ACC_W      = 30;

   localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(2 ** (LIDX_W - 1) - 1);
   localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

   localparam logic [CSR_IDX_W-1:0] CSR_NUM_X   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_Y   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_Z   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OVL_X   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_OVL_Y   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_OVL_Z   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCKED = 3'd6;

   localparam logic CMD_LIST  = 1'b0;
   localparam logic CMD_LOCAL = 1'b1;

   typedef struct packed {
      logic             go;
      logic [DVD_W-1:0] dividend;
      logic [DVS_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DVD_W-1:0] quot;
      logic [DVS_W-1:0] rem;
   } div_rsp_type;

endpackage

`default_nettype wire

// ===== src/csom_div.sv =====
// Radix-2 restoring divider shared by the mapper sequencer, one quotient bit
// per cycle. Depends on csom_pkg for widths and request/response types.
`default_nettype none

module csom_div (
   input  wire                   clock,
   input  wire                   reset,
   input  csom_pkg::div_req_type div_req,
   output csom_pkg::div_rsp_type div_rsp
);
   import csom_pkg::*;

   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DVD_W-1:0]     quo_ff, quo_in;
   logic [DVS_W-1:0]     rem_ff, rem_in;
   logic [DVS_W-1:0]     dvs_ff, dvs_in;
   logic [DVS_W:0]       trial;
   logic [DVS_W:0]       diff;
   logic                 ge;

   assign trial = {rem_ff, quo_ff[DVD_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign ge    = (trial >= {1'b0, dvs_ff});

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (div_req.go) begin
         run_in = 1'b1;
         cnt_in = '0;
         quo_in = div_req.dividend;
         rem_in = '0;
         dvs_in = div_req.divisor;
      end else if (run_ff) begin
         quo_in = {quo_ff[DVD_W-2:0], ge};
         rem_in = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
         cnt_in = cnt_ff + DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(DVD_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quo_ff;
   assign div_rsp.rem  = rem_ff;

endmodule

`default_nettype wire

// ===== src/cellset_ownership_mapper_unit.sv =====
// Maps a 3D cellset grid onto ranks: lists a rank's cellsets or gives a
// cellset's local index. Depends on csom_pkg, csom_div and the assert header.
//
// A command is taken when start is high and busy is low; busy then stays high
// until the last result word leaves. Result words appear for one cycle each,
// marked by rsp_valid, and cannot be held off by the receiver. All division
// and multiplication runs through one shared radix-2 divider and one shared
// registered multiplier under a sequencer. Listing a rank (cmd 0) runs a
// set-up of four divisions plus nine multiply and control steps and then
// gives one ID per cycle, overload_x*overload_y*overload_z words back to
// back with the final one marked by rsp_last. A local-index query (cmd 1)
// runs six divisions plus eight steps to its one result word. If the
// configuration yields zero ranks on some axis, a single error word with
// rsp_last set appears in the cycle after start and busy is not raised.
`default_nettype none
`include "cellset_ownership_mapper_unit_assert.svh"

module cellset_ownership_mapper_unit #(
   parameter int MAX_CELLSETS_PER_AXIS = 64,
   parameter int MAX_OVERLOAD          = 4
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   start,
   output logic                                  busy,
   input  wire                                   req_cmd,
   input  wire  [csom_pkg::ID_W-1:0]             req_rank_id,
   input  wire  [csom_pkg::ID_W-1:0]             req_query_cellset,
   output logic                                  rsp_valid,
   output logic [csom_pkg::ID_W-1:0]             rsp_cellset_out,
   output logic signed [csom_pkg::LIDX_W-1:0]    rsp_local_index,
   output logic                                  rsp_last,
   output logic                                  rsp_error,
   input  wire                                   csr_we,
   input  wire  [csom_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire  [csom_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import csom_pkg::*;

   typedef enum logic [20:0] {
      S_IDLE = 21'h000001,
      S_P0   = 21'h000002,
      S_P1   = 21'h000004,
      S_K    = 21'h000008,
      S_J    = 21'h000010,
      S_SC0  = 21'h000020,
      S_SC1  = 21'h000040,
      S_SC2  = 21'h000080,
      S_NN   = 21'h000100,
      S_C0A  = 21'h000200,
      S_C0B  = 21'h000400,
      S_C0C  = 21'h000800,
      S_C0D  = 21'h001000,
      S_C0E  = 21'h002000,
      S_EMIT = 21'h004000,
      S_Q1   = 21'h008000,
      S_Q2   = 21'h010000,
      S_L0   = 21'h020000,
      S_L1   = 21'h040000,
      S_L2   = 21'h080000,
      S_L3   = 21'h100000
   } state_type;

   // configuration registers
   logic [NCNT_W-1:0] cfg_n_ff  [3];
   logic [OVL_W-1:0]  cfg_ov_ff [3];
   logic [2:0]        cfg_blk_ff;

   logic [NCNT_W-1:0] n_cl  [3];
   logic [OVL_W-1:0]  ov_cl [3];
   logic              cfg_err;

   state_type         state_ff, state_in;
   logic              launched_ff, launched_in;
   logic              cmd_ff, cmd_in;
   logic [ID_W-1:0]   rank_ff, rank_in;
   logic [ID_W-1:0]   qry_ff, qry_in;
   logic [NCNT_W-1:0] n_ff  [3];
   logic [NCNT_W-1:0] n_in  [3];
   logic [OVL_W-1:0]  ov_ff [3];
   logic [OVL_W-1:0]  ov_in [3];
   logic [2:0]        blk_ff, blk_in;
   logic [NCNT_W-1:0] p0_ff, p0_in;
   logic [DVS_W-1:0]  krem_ff, krem_in;
   logic [BASE_W-1:0] b_ff [3];
   logic [BASE_W-1:0] b_in [3];
   logic [DVS_W-1:0]  nn_ff, nn_in;
   logic [ID_W-1:0]   qk_ff, qk_in;
   logic [DVS_W-1:0]  ij_ff, ij_in;
   logic [ID_W-1:0]   qj_ff, qj_in;
   logic [NCNT_W-1:0] qi_ff, qi_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [ACC_W-1:0] lsum;
   logic [OVL_W-1:0]  dx_ff, dx_in;
   logic [ID_W-1:0]   dy_ff, dy_in;
   logic [ID_W-1:0]   dz_ff, dz_in;
   logic [ID_W-1:0]   id_ff, id_in;
   logic [ID_W-1:0]   row_ff, row_in;
   logic [ID_W-1:0]   pln_ff, pln_in;
   logic [OVL_W-1:0]  tx_ff, tx_in;
   logic [OVL_W-1:0]  ty_ff, ty_in;
   logic [OVL_W-1:0]  tz_ff, tz_in;
   logic              lx, ly, lz;

   logic signed [MUL_A_W-1:0] mul_a;
   logic [MUL_B_W-1:0]        mul_b;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]          rsp_cs_ff, rsp_cs_in;
   logic signed [LIDX_W-1:0] rsp_li_ff, rsp_li_in;
   logic                     rsp_last_ff, rsp_last_in;
   logic                     rsp_err_ff, rsp_err_in;

   div_req_type div_req;
   div_rsp_type div_rsp;

   csom_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_n_ff[0]  <= NCNT_W'(1);
         cfg_n_ff[1]  <= NCNT_W'(1);
         cfg_n_ff[2]  <= NCNT_W'(1);
         cfg_ov_ff[0] <= OVL_W'(1);
         cfg_ov_ff[1] <= OVL_W'(1);
         cfg_ov_ff[2] <= OVL_W'(1);
         cfg_blk_ff   <= 3'b111;
      end else if (csr_we) begin
         case (csr_index)
            CSR_NUM_X:   cfg_n_ff[0]  <= csr_wdata[NCNT_W-1:0];
            CSR_NUM_Y:   cfg_n_ff[1]  <= csr_wdata[NCNT_W-1:0];
            CSR_NUM_Z:   cfg_n_ff[2]  <= csr_wdata[NCNT_W-1:0];
            CSR_OVL_X:   cfg_ov_ff[0] <= csr_wdata[OVL_W-1:0];
            CSR_OVL_Y:   cfg_ov_ff[1] <= csr_wdata[OVL_W-1:0];
            CSR_OVL_Z:   cfg_ov_ff[2] <= csr_wdata[OVL_W-1:0];
            CSR_BLOCKED: cfg_blk_ff   <= csr_wdata[2:0];
            default: ;
         endcase
      end
   end

   // clamp and check for an empty rank axis
   always_comb begin
      cfg_err = 1'b0;
      for (int d = 0; d < 3; d++) begin
         n_cl[d]  = (int'(cfg_n_ff[d]) > MAX_CELLSETS_PER_AXIS) ?
                    NCNT_W'(MAX_CELLSETS_PER_AXIS) : cfg_n_ff[d];
         ov_cl[d] = (int'(cfg_ov_ff[d]) > MAX_OVERLOAD) ?
                    OVL_W'(MAX_OVERLOAD) : cfg_ov_ff[d];
         if ((ov_cl[d] == '0) || (n_cl[d] < NCNT_W'(ov_cl[d]))) begin
            cfg_err = 1'b1;
         end
      end
   end

   assign prod_in = mul_a * $signed({1'b0, mul_b});
   assign lsum    = acc_ff + $signed(prod_ff[ACC_W-1:0]);

   assign lx = (tx_ff == ov_ff[0] - OVL_W'(1));
   assign ly = (ty_ff == ov_ff[1] - OVL_W'(1));
   assign lz = (tz_ff == ov_ff[2] - OVL_W'(1));

   always_comb begin
      state_in    = state_ff;
      launched_in = launched_ff;
      cmd_in      = cmd_ff;
      rank_in     = rank_ff;
      qry_in      = qry_ff;
      n_in        = n_ff;
      ov_in       = ov_ff;
      blk_in      = blk_ff;
      p0_in       = p0_ff;
      krem_in     = krem_ff;
      b_in        = b_ff;
      nn_in       = nn_ff;
      qk_in       = qk_ff;
      ij_in       = ij_ff;
      qj_in       = qj_ff;
      qi_in       = qi_ff;
      acc_in      = acc_ff;
      dx_in       = dx_ff;
      dy_in       = dy_ff;
      dz_in       = dz_ff;
      id_in       = id_ff;
      row_in      = row_ff;
      pln_in      = pln_ff;
      tx_in       = tx_ff;
      ty_in       = ty_ff;
      tz_in       = tz_ff;
      mul_a       = '0;
      mul_b       = '0;
      div_req     = '0;
      rsp_valid_in = 1'b0;
      rsp_cs_in    = rsp_cs_ff;
      rsp_li_in    = rsp_li_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_err_in   = rsp_err_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd_in  = req_cmd;
               rank_in = req_rank_id;
               qry_in  = req_query_cellset;
               n_in    = n_cl;
               ov_in   = ov_cl;
               blk_in  = cfg_blk_ff;
               if (cfg_err) begin
                  rsp_valid_in = 1'b1;
                  rsp_cs_in    = '0;
                  rsp_li_in    = '0;
                  rsp_last_in  = 1'b1;
                  rsp_err_in   = 1'b1;
               end else begin
                  state_in = S_P0;
               end
            end
         end
         S_P0: begin
            div_req.go       = !launched_ff;
            div_req.dividend = DVD_W'(n_ff[0]);
            div_req.divisor  = DVS_W'(ov_ff[0]);
            launched_in      = 1'b1;
            if (launched_ff && div_rsp.done) begin
               launched_in = 1'b0;
               p0_in       = div_rsp.quot[NCNT_W-1:0];
               state_in    = S_P1;
            end
         end
         S_P1: begin
            div_req.go       = !launched_ff;
            div_req.dividend = DVD_W'(n_ff[1]);
            div_req.divisor  = DVS_W'(ov_ff[1]);
            launched_in      = 1'b1;
            mul_a            = $signed(MUL_A_W'(div_rsp.quot));
            mul_b            = MUL_B_W'(p0_ff);
            if (launched_ff && div_rsp.done) begin
               launched_in = 1'b0;
               state_in    = S_K;
            end
         end
         S_K: begin
            div_req.go       = !launched_ff;
            div_req.dividend = rank_ff;
            div_req.divisor  = prod_ff[DVS_W-1:0];
            launched_in      = 1'b1;
            if (launched_ff && div_rsp.done) begin
               launched_in = 1'b0;
               b_in[2]     = BASE_W'(div_rsp.quot);
               krem_in     = div_rsp.rem;
               state_in    = S_J;
            end
         end
         S_J: begin
            div_req.go       = !launched_ff;
            div_req.dividend = DVD_W'(krem_ff);
            div_req.divisor  = DVS_W'(p0_ff);
            launched_in      = 1'b1;
            if (launched_ff && div_rsp.done) begin
               launched_in = 1'b0;
               b_in[1]     = BASE_W'(div_rsp.quot);
               b_in[0]     = BASE_W'(div_rsp.rem);
               state_in    = S_SC0;
            end
         end
         S_SC0: begin
            mul_a    = $signed(MUL_A_W'(b_ff[0]));
            mul_b    = MUL_B_W'(ov_ff[0]);
            state_in = S_SC1;
         end
         S_SC1: begin
            if (blk_ff[0]) begin
               b_in[0] = prod_ff[BASE_W-1:0];
            end
            mul_a    = $signed(MUL_A_W'(b_ff[1]));
            mul_b    = MUL_B_W'(ov_ff[1]);
            state_in = S_SC2;
         end
         S_SC2: begin
            if (blk_ff[1]) begin
               b_in[1] = prod_ff[BASE_W-1:0];
            end
            mul_a    = $signed(MUL_A_W'(b_ff[2]));
            mul_b    = MUL_B_W'(ov_ff[2]);
            state_in = S_NN;
         end
         S_NN: begin
            if (blk_ff[2]) begin
               b_in[2] = prod_ff[BASE_W-1:0];
            end
            mul_a    = $signed(MUL_A_W'(n_ff[0]));
            mul_b    = MUL_B_W'(n_ff[1]);
            state_in = (cmd_ff == CMD_LIST) ? S_C0A : S_Q1;
         end
         S_C0A: begin
            nn_in    = prod_ff[DVS_W-1:0];
            mul_a    = $signed(MUL_A_W'(b_ff[1]));
            mul_b    = MUL_B_W'(n_ff[0]);
            state_in = S_C0B;
         end
         S_C0B: begin
            id_in    = b_ff[0][ID_W-1:0] + prod_ff[ID_W-1:0];
            mul_a    = $signed(MUL_A_W'(b_ff[2]));
            mul_b    = nn_ff;
            state_in = S_C0C;
         end
         S_C0C: begin
            id_in    = id_ff + prod_ff[ID_W-1:0];
            mul_a    = $signed(MUL_A_W'(blk_ff[1] ? OVL_W'(1) : ov_ff[1]));
            mul_b    = MUL_B_W'(n_ff[0]);
            state_in = S_C0D;
         end
         S_C0D: begin
            dy_in    = prod_ff[ID_W-1:0];
            mul_a    = $signed(MUL_A_W'(blk_ff[2] ? OVL_W'(1) : ov_ff[2]));
            mul_b    = nn_ff;
            state_in = S_C0E;
         end
         S_C0E: begin
            dz_in    = prod_ff[ID_W-1:0];
            dx_in    = blk_ff[0] ? OVL_W'(1) : ov_ff[0];
            row_in   = id_ff;
            pln_in   = id_ff;
            tx_in    = '0;
            ty_in    = '0;
            tz_in    = '0;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            rsp_valid_in = 1'b1;
            rsp_cs_in    = id_ff;
            rsp_li_in    = '0;
            rsp_last_in  = lx && ly && lz;
            rsp_err_in   = 1'b0;
            priority if (!lx) begin
               tx_in = tx_ff + OVL_W'(1);
               id_in = id_ff + ID_W'(dx_ff);
            end else if (!ly) begin
               tx_in  = '0;
               ty_in  = ty_ff + OVL_W'(1);
               row_in = row_ff + dy_ff;
               id_in  = row_ff + dy_ff;
            end else if (!lz) begin
               tx_in  = '0;
               ty_in  = '0;
               tz_in  = tz_ff + OVL_W'(1);
               pln_in = pln_ff + dz_ff;
               row_in = pln_ff + dz_ff;
               id_in  = pln_ff + dz_ff;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_Q1: begin
            div_req.go       = !launched_ff;
            div_req.dividend = qry_ff;
            div_req.divisor  = prod_ff[DVS_W-1:0];
            launched_in      = 1'b1;
            if (launched_ff && div_rsp.done) begin
               launched_in = 1'b0;
               qk_in       = div_rsp.quot;
               ij_in       = div_rsp.rem;
               state_in    = S_Q2;
            end
         end
         S_Q2: begin
            div_req.go       = !launched_ff;
            div_req.dividend = DVD_W'(ij_ff);
            div_req.divisor  = DVS_W'(n_ff[0]);
            launched_in      = 1'b1;
            if (launched_ff && div_rsp.done) begin
               launched_in = 1'b0;
               qj_in       = div_rsp.quot;
               qi_in       = div_rsp.rem[NCNT_W-1:0];
               state_in    = S_L0;
            end
         end
         S_L0: begin
            mul_a    = $signed(MUL_A_W'(qj_ff)) - $signed(MUL_A_W'(b_ff[1]));
            mul_b    = MUL_B_W'(ov_ff[0]);
            state_in = S_L1;
         end
         S_L1: begin
            acc_in   = $signed(ACC_W'(qi_ff)) - $signed(ACC_W'(b_ff[0]))
                       + $signed(prod_ff[ACC_W-1:0]);
            mul_a    = $signed(MUL_A_W'(ov_ff[0]));
            mul_b    = MUL_B_W'(ov_ff[1]);
            state_in = S_L2;
         end
         S_L2: begin
            mul_a    = $signed(MUL_A_W'(qk_ff)) - $signed(MUL_A_W'(b_ff[2]));
            mul_b    = prod_ff[MUL_B_W-1:0];
            state_in = S_L3;
         end
         S_L3: begin
            rsp_valid_in = 1'b1;
            rsp_cs_in    = '0;
            rsp_last_in  = 1'b1;
            rsp_err_in   = 1'b0;
            priority if (lsum > SAT_HI) begin
               rsp_li_in = SAT_HI[LIDX_W-1:0];
            end else if (lsum < SAT_LO) begin
               rsp_li_in = SAT_LO[LIDX_W-1:0];
            end else begin
               rsp_li_in = lsum[LIDX_W-1:0];
            end
            state_in = S_IDLE;
         end
         default: begin
            state_in    = S_IDLE;
            launched_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         launched_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         launched_ff  <= launched_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff      <= cmd_in;
      rank_ff     <= rank_in;
      qry_ff      <= qry_in;
      n_ff        <= n_in;
      ov_ff       <= ov_in;
      blk_ff      <= blk_in;
      p0_ff       <= p0_in;
      krem_ff     <= krem_in;
      b_ff        <= b_in;
      nn_ff       <= nn_in;
      qk_ff       <= qk_in;
      ij_ff       <= ij_in;
      qj_ff       <= qj_in;
      qi_ff       <= qi_in;
      acc_ff      <= acc_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      dz_ff       <= dz_in;
      id_ff       <= id_in;
      row_ff      <= row_in;
      pln_ff      <= pln_in;
      tx_ff       <= tx_in;
      ty_ff       <= ty_in;
      tz_ff       <= tz_in;
      prod_ff     <= prod_in;
      rsp_cs_ff   <= rsp_cs_in;
      rsp_li_ff   <= rsp_li_in;
      rsp_last_ff <= rsp_last_in;
      rsp_err_ff  <= rsp_err_in;
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_cellset_out = rsp_cs_ff;
   assign rsp_local_index = rsp_li_ff;
   assign rsp_last        = rsp_last_ff;
   assign rsp_error       = rsp_err_ff;

   `CSOM_ASSERT_IMP(a_err_is_last, clock, reset, rsp_valid && rsp_error, rsp_last)
   `CSOM_ASSERT_NXT(a_list_contig, clock, reset, rsp_valid && !rsp_last, rsp_valid)
   `CSOM_ASSERT_IMP(a_idle_only_last, clock, reset, rsp_valid && !busy, rsp_last)

endmodule

`default_nettype wire

// ===== tb/sv/cellset_ownership_mapper_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for cellset_ownership_mapper_unit: random commands across many grid
// settings, every result word predicted and compared in order. Depends on csom_pkg and the RTL.

module cellset_ownership_mapper_unit_tb;
   import csom_pkg::*;

   localparam int MAX_CS       = 64;
   localparam int MAX_OVL      = 4;
   localparam int RANDOM_ITEMS = 430;
   localparam int CYCLE_LIMIT  = 900000;
   localparam int PRINT_CAP    = 100;

   typedef struct {
      logic [ID_W-1:0]          cellset;
      logic signed [LIDX_W-1:0] lidx;
      logic                     last;
      logic                     err;
   } owner_word_t;

   class owned_cellset_board;
      bit [NCNT_W-1:0] num_cs [3];
      bit [OVL_W-1:0]  ovl [3];
      bit [2:0]        blocked;
      owner_word_t     owed_words [$];
      int              mismatches;

      function new();
         for (int d = 0; d < 3; d++) begin
            num_cs[d] = 1;
            ovl[d]    = 1;
         end
         blocked    = 3'b111;
         mismatches = 0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
         case (index)
            CSR_NUM_X:   num_cs[0] = value;
            CSR_NUM_Y:   num_cs[1] = value;
            CSR_NUM_Z:   num_cs[2] = value;
            CSR_OVL_X:   ovl[0] = value[OVL_W-1:0];
            CSR_OVL_Y:   ovl[1] = value[OVL_W-1:0];
            CSR_OVL_Z:   ovl[2] = value[OVL_W-1:0];
            CSR_BLOCKED: blocked = value[2:0];
            default: ;
         endcase
      endfunction

      function longint eff_count(int d);
         return (num_cs[d] > MAX_CS) ? MAX_CS : longint'(num_cs[d]);
      endfunction

      function longint eff_ovl(int d);
         return (ovl[d] > MAX_OVL) ? MAX_OVL : longint'(ovl[d]);
      endfunction

      function longint rank_count();
         longint prod;
         prod = 1;
         for (int d = 0; d < 3; d++)
            prod = (eff_ovl(d) != 0) ? prod * (eff_count(d) / eff_ovl(d)) : 0;
         return prod;
      endfunction

      function longint grid_size();
         return eff_count(0) * eff_count(1) * eff_count(2);
      endfunction

      function int pending_count();
         return owed_words.size();
      endfunction

      function void note_command(logic cmd, logic [ID_W-1:0] rank, logic [ID_W-1:0] query);
         longint n [3];
         longint ov [3];
         longint p [3];
         longint org [3];
         longint c [3];
         longint plane, rest, id, nn, qk, qj, qi, idx;
         int total, seen;
         for (int d = 0; d < 3; d++) begin
            n[d]  = eff_count(d);
            ov[d] = eff_ovl(d);
            p[d]  = (ov[d] != 0) ? n[d] / ov[d] : 0;
         end
         if (p[0] == 0 || p[1] == 0 || p[2] == 0) begin
            owed_words.push_back('{cellset: '0, lidx: '0, last: 1'b1, err: 1'b1});
            return;
         end
         plane  = p[0] * p[1];
         org[2] = longint'(rank) / plane;
         rest   = longint'(rank) - org[2] * plane;
         org[1] = rest / p[0];
         org[0] = rest - org[1] * p[0];
         for (int d = 0; d < 3; d++)
            if (blocked[d]) org[d] = org[d] * ov[d];
         if (cmd == CMD_LIST) begin
            total = int'(ov[0] * ov[1] * ov[2]);
            seen  = 0;
            for (longint tz = 0; tz < ov[2]; tz++)
               for (longint ty = 0; ty < ov[1]; ty++)
                  for (longint tx = 0; tx < ov[0]; tx++) begin
                     c[0] = blocked[0] ? org[0] + tx : org[0] + tx * ov[0];
                     c[1] = blocked[1] ? org[1] + ty : org[1] + ty * ov[1];
                     c[2] = blocked[2] ? org[2] + tz : org[2] + tz * ov[2];
                     id   = c[0] + n[0] * c[1] + n[0] * n[1] * c[2];
                     seen++;
                     owed_words.push_back('{cellset: ID_W'(id), lidx: '0,
                                            last: (seen == total), err: 1'b0});
                  end
         end else begin
            nn  = n[0] * n[1];
            qk  = longint'(query) / nn;
            qj  = (longint'(query) % nn) / n[0];
            qi  = (longint'(query) % nn) % n[0];
            idx = (qi - org[0]) + ov[0] * (qj - org[1]) + ov[0] * ov[1] * (qk - org[2]);
            if (idx > 2047) idx = 2047;
            if (idx < -2048) idx = -2048;
            owed_words.push_back('{cellset: '0, lidx: LIDX_W'(idx), last: 1'b1, err: 1'b0});
         end
      endfunction

      task report_mismatch(string what);
         if (mismatches < PRINT_CAP) $display("mismatch: %s", what);
         mismatches++;
      endtask

      task check_word(logic [ID_W-1:0] cs, logic signed [LIDX_W-1:0] li, logic lst, logic er);
         owner_word_t w;
         if (owed_words.size() == 0) begin
            report_mismatch($sformatf("word cs=%0d li=%0d with nothing pending", cs, li));
            return;
         end
         w = owed_words.pop_front();
         if (cs !== w.cellset)
            report_mismatch($sformatf("cellset_out got %0d want %0d", cs, w.cellset));
         if (li !== w.lidx)
            report_mismatch($sformatf("local_index got %0d want %0d", li, w.lidx));
         if (lst !== w.last)
            report_mismatch($sformatf("last got %b want %b", lst, w.last));
         if (er !== w.err)
            report_mismatch($sformatf("error got %b want %b", er, w.err));
      endtask
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     req_cmd = CMD_LIST;
   logic [ID_W-1:0]          req_rank_id = '0;
   logic [ID_W-1:0]          req_query_cellset = '0;
   logic                     csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]     csr_index = CSR_NUM_X;
   logic [CSR_DATA_W-1:0]    csr_wdata = '0;
   wire                      busy;
   wire                      rsp_valid;
   wire [ID_W-1:0]           rsp_cellset_out;
   wire signed [LIDX_W-1:0]  rsp_local_index;
   wire                      rsp_last;
   wire                      rsp_error;

   owned_cellset_board board = new();
   int          issued = 0;
   bit          steady = 1'b0;
   int unsigned cycle_count = 0;

   cellset_ownership_mapper_unit #(
      .MAX_CELLSETS_PER_AXIS(MAX_CS),
      .MAX_OVERLOAD(MAX_OVL)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_cmd(req_cmd),
      .req_rank_id(req_rank_id),
      .req_query_cellset(req_query_cellset),
      .rsp_valid(rsp_valid),
      .rsp_cellset_out(rsp_cellset_out),
      .rsp_local_index(rsp_local_index),
      .rsp_last(rsp_last),
      .rsp_error(rsp_error),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         board.check_word(rsp_cellset_out, rsp_local_index, rsp_last, rsp_error);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("cellset_ownership_mapper_unit regression: fail");
         $finish;
      end
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 15);
      return $urandom_range(20, 250);
   endfunction

   // hold start low until every owed word is back and the block is idle
   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (board.pending_count() != 0 || busy);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] index, input int value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= CSR_DATA_W'(value);
      @(posedge clock);
      board.set_reg(index, CSR_DATA_W'(value));
   endtask

   task automatic program_grid(input int nx, input int ny, input int nz,
                               input int ox, input int oy, input int oz, input int mask);
      drain();
      write_reg(CSR_NUM_X, nx);
      write_reg(CSR_NUM_Y, ny);
      write_reg(CSR_NUM_Z, nz);
      write_reg(CSR_OVL_X, ox);
      write_reg(CSR_OVL_Y, oy);
      write_reg(CSR_OVL_Z, oz);
      write_reg(CSR_BLOCKED, mask);
      csr_we <= 1'b0;
   endtask

   task automatic issue_command(input logic cmd, input logic [ID_W-1:0] rank,
                                input logic [ID_W-1:0] query);
      int gap;
      start             <= 1'b1;
      req_cmd           <= cmd;
      req_rank_id       <= rank;
      req_query_cellset <= query;
      @(posedge clock);
      while (busy) @(posedge clock);
      board.note_command(cmd, rank, query);
      issued++;
      gap = steady ? 0 : pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic issue_random();
      longint ranks, cells;
      logic [ID_W-1:0] rank, query;
      ranks = board.rank_count();
      cells = board.grid_size();
      if (ranks > 0 && $urandom_range(0, 4) != 0)
         rank = ID_W'($urandom_range(0, int'(ranks - 1)));
      else
         rank = ID_W'($urandom);
      if (cells > 0 && $urandom_range(0, 4) != 0)
         query = ID_W'($urandom_range(0, int'(cells - 1)));
      else
         query = ID_W'($urandom);
      issue_command(($urandom_range(0, 1) == 1) ? CMD_LOCAL : CMD_LIST, rank, query);
      if ($urandom_range(0, 39) == 0) drain();
   endtask

   task automatic random_phase();
      int kind, count, axis;
      int cnt [3];
      int ov [3];
      kind = $urandom_range(0, 11);
      for (int d = 0; d < 3; d++) begin
         if (kind == 1) begin
            cnt[d] = $urandom_range(0, 1) ? $urandom_range(65, 127) : $urandom_range(4, 64);
            ov[d]  = $urandom_range(1, 7);
         end else if (kind == 2) begin
            cnt[d] = $urandom_range(32, 64);
            ov[d]  = $urandom_range(1, 4);
         end else begin
            cnt[d] = $urandom_range(1, 10);
            ov[d]  = $urandom_range(1, (cnt[d] < 4) ? cnt[d] : 4);
         end
      end
      if (kind == 0) begin
         axis = $urandom_range(0, 2);
         case ($urandom_range(0, 2))
            0: cnt[axis] = 0;
            1: ov[axis] = 0;
            default: begin
               cnt[axis] = $urandom_range(1, 3);
               ov[axis]  = $urandom_range(cnt[axis] + 1, 7);
            end
         endcase
      end
      program_grid(cnt[0], cnt[1], cnt[2], ov[0], ov[1], ov[2], $urandom_range(0, 7));
      steady = ($urandom_range(0, 3) == 0);
      count  = (kind == 0) ? $urandom_range(3, 6) : $urandom_range(20, 60);
      repeat (count) issue_random();
   endtask

   initial begin
      int directed_done;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      issue_command(CMD_LIST, 0, 0);
      issue_command(CMD_LOCAL, 0, 0);

      program_grid(64, 64, 64, 4, 4, 4, 7);
      issue_command(CMD_LIST, 0, 0);
      issue_command(CMD_LIST, 4095, 0);
      issue_command(CMD_LIST, 18'h3FFFF, 0);
      issue_command(CMD_LOCAL, 0, 18'h3FFFF);
      issue_command(CMD_LOCAL, 18'h3FFFF, 0);
      drain();

      program_grid(64, 64, 64, 4, 4, 4, 0);
      issue_command(CMD_LIST, 0, 0);
      issue_command(CMD_LIST, 4095, 0);
      issue_command(CMD_LOCAL, 5, 1000);

      program_grid(127, 100, 65, 7, 5, 6, 5);
      issue_command(CMD_LIST, 1, 0);
      issue_command(CMD_LOCAL, 2, 300);

      program_grid(0, 4, 4, 1, 1, 1, 7);
      issue_command(CMD_LIST, 7, 0);
      issue_command(CMD_LOCAL, 3, 9);
      program_grid(4, 4, 4, 1, 0, 1, 3);
      issue_command(CMD_LIST, 0, 0);
      program_grid(4, 4, 2, 1, 1, 3, 6);
      issue_command(CMD_LOCAL, 0, 5);

      program_grid(1, 1, 64, 1, 1, 4, 3);
      issue_command(CMD_LOCAL, 0, 18'h3FFFF);
      issue_command(CMD_LIST, 15, 0);

      program_grid(5, 3, 7, 2, 1, 3, 2);
      issue_command(CMD_LIST, 3, 0);
      issue_command(CMD_LOCAL, 3, 17);

      directed_done = issued;
      while (issued < directed_done + RANDOM_ITEMS) random_phase();

      drain();
      repeat (20) @(posedge clock);
      if (board.mismatches == 0)
         $display("cellset_ownership_mapper_unit regression: pass");
      else
         $display("cellset_ownership_mapper_unit regression: fail");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+src
src/csom_pkg.sv
src/csom_div.sv
src/cellset_ownership_mapper_unit.sv
tb/sv/cellset_ownership_mapper_unit_tb.sv
